[sv/swp_pkg.sv]
// ============================================================================
// swp_pkg - shared types, constants and fixed-point helpers
// Power tables (log2 / exp2), register map and pipeline sizing for the
// soil water potential block.
// ============================================================================
package swp_pkg;

    // Power table resolution: 2^POW_TABLE_BITS + 1 entries per table
    localparam int POW_TABLE_BITS = 8;
    localparam int TAB_N          = (1 << POW_TABLE_BITS) + 1;
    localparam int LOG_SH         = 31 - POW_TABLE_BITS;
    localparam int EXP_SH         = 16 - POW_TABLE_BITS;

    // Pipeline depth: divider stages plus the math stages
    localparam int DIV_STG = 4;
    localparam int NSTG    = 14;

    localparam logic [40:0] PSI_LIMIT = 41'd1 << 40;

    typedef logic [TAB_N-1:0][17:0] t_tab;

    // Register map, index = paddr[4:2]
    typedef enum logic [2:0] {
        REG_DEPTH_MM     = 3'd0,
        REG_THETA_SAT    = 3'd1,
        REG_THETA_RES    = 3'd2,
        REG_THETA_FC     = 3'd3,
        REG_INV_ALPHA_CM = 3'd4,
        REG_EXP_M        = 3'd5,
        REG_EXP_INV_BETA = 3'd6
    } t_reg_idx;

    // Side information carried along the pipeline
    typedef struct packed {
        logic [15:0] vol_content;
        logic        dry;
        logic        wet;
    } t_side;

    // 20 fractional bits of log2(x / 2^30), x in [2^30, 2^31]
    function automatic logic [19:0] frac_log20(input logic [63:0] xin);
        logic [63:0] x;
        logic [19:0] res;
        x   = xin;
        res = '0;
        for (int k = 0; k < 20; k++) begin
            x   = (x * x) >> 30;
            res = {res[18:0], 1'b0};
            if (x >= (64'd1 << 31)) begin
                x      = x >> 1;
                res[0] = 1'b1;
            end
        end
        return res;
    endfunction

    function automatic t_tab build_log_tab();
        t_tab        tab;
        logic [63:0] x;
        logic [20:0] f;
        for (int i = 0; i < TAB_N; i++) begin
            x      = (64'd1 << 30) + (64'(i) << (30 - POW_TABLE_BITS));
            f      = {1'b0, frac_log20(x)} + 21'd8;
            tab[i] = 18'(f >> 4);
        end
        return tab;
    endfunction

    // Smallest Q1.16 value whose log reaches each table point
    function automatic t_tab build_exp_tab();
        t_tab        tab;
        logic [19:0] target;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] mid;
        for (int i = 0; i < TAB_N - 1; i++) begin
            target = 20'(i << (20 - POW_TABLE_BITS));
            lo     = 32'd65536;
            hi     = 32'd131072;
            while (lo < hi) begin
                mid = (lo + hi) >> 1;
                if (frac_log20(64'(mid) << 14) >= target) begin
                    hi = mid;
                end else begin
                    lo = mid + 32'd1;
                end
            end
            tab[i] = 18'(lo);
        end
        tab[TAB_N-1] = 18'd131072;
        return tab;
    endfunction

    localparam t_tab LOG_TAB = build_log_tab();
    localparam t_tab EXP_TAB = build_exp_tab();

    // Position of the leading one (0 for zero)
    function automatic logic [5:0] msb57(input logic [56:0] x);
        logic [5:0] e;
        e = '0;
        for (int b = 1; b < 57; b++) begin
            if (x[b]) begin
                e = 6'(b);
            end
        end
        return e;
    endfunction

    // log2 in Q.16 from leading-one position e and normalized mantissa t
    function automatic logic [21:0] log2_q16(input logic [5:0] e, input logic [31:0] t);
        logic [POW_TABLE_BITS-1:0] idx;
        logic [LOG_SH-1:0]         rem;
        logic [17:0]               lo;
        logic [17:0]               hi;
        logic [47:0]               dlt;
        idx = t[30 -: POW_TABLE_BITS];
        rem = t[LOG_SH-1:0];
        lo  = LOG_TAB[{1'b0, idx}];
        hi  = LOG_TAB[{1'b0, idx} + 1'b1];
        dlt = 48'(hi - lo) * 48'(rem);
        return 22'({e, 16'h0000}) + 22'(lo) + 22'(dlt >> LOG_SH);
    endfunction

    // 2^(f/65536) in Q1.16
    function automatic logic [17:0] exp2_q16(input logic [15:0] f);
        logic [POW_TABLE_BITS-1:0] idx;
        logic [EXP_SH-1:0]         rem;
        logic [17:0]               lo;
        logic [17:0]               hi;
        logic [35:0]               dlt;
        idx = f[15 -: POW_TABLE_BITS];
        rem = f[EXP_SH-1:0];
        lo  = EXP_TAB[{1'b0, idx}];
        hi  = EXP_TAB[{1'b0, idx} + 1'b1];
        dlt = 36'(hi - lo) * 36'(rem);
        return lo + 18'(dlt >> EXP_SH);
    endfunction

endpackage

[sv/swp_if.sv]
// ============================================================================
// swp_if - request and result channels
// Valid/ready channels carrying one soil water sample in and one result out.
// ============================================================================
interface swp_in_if;
    logic        valid;
    logic        ready;
    logic [23:0] soil_water;

    modport source (output valid, output soil_water, input ready);
    modport sink   (input valid, input soil_water, output ready);
endinterface

interface swp_out_if;
    logic               valid;
    logic               ready;
    logic signed [40:0] psi_pa;
    logic        [15:0] vol_content;
    logic        [23:0] water_at_saturation;
    logic        [23:0] water_at_field_capacity;
    logic               dry_flag;
    logic               wet_clamped;

    modport source (output valid, output psi_pa, output vol_content,
                    output water_at_saturation, output water_at_field_capacity,
                    output dry_flag, output wet_clamped, input ready);
    modport sink   (input valid, input psi_pa, input vol_content,
                    input water_at_saturation, input water_at_field_capacity,
                    input dry_flag, input wet_clamped, output ready);
endinterface

[sv/swp_div.sv]
// ============================================================================
// swp_div - pipelined restoring divider
// Volumetric content = soil_water * 256 / depth, saturated to 16 bits.
// Four quotient bits are resolved per stage; stage k loads on i_adv[k].
// ============================================================================
module swp_div (
    input  logic                         i_clk,
    input  logic [swp_pkg::DIV_STG-1:0]  i_adv,
    input  logic [23:0]                  i_soil_water,
    input  logic [15:0]                  i_depth_mm,
    output logic [15:0]                  o_vol_content
);

    localparam int STEP = 16 / swp_pkg::DIV_STG;

    // Partial remainder / dividend tail only needed between stages
    logic [15:0] r_rem [swp_pkg::DIV_STG-1];
    logic [15:0] r_lo  [swp_pkg::DIV_STG-1];
    logic [15:0] r_q   [swp_pkg::DIV_STG];
    logic        r_ovf [swp_pkg::DIV_STG];

    logic [15:0] w_rem [swp_pkg::DIV_STG];
    logic [15:0] w_lo  [swp_pkg::DIV_STG];
    logic [15:0] w_q   [swp_pkg::DIV_STG];
    logic        w_ovf [swp_pkg::DIV_STG];

    // Stage inputs: quotient above 16 bits (or zero depth) saturates
    assign w_rem[0] = i_soil_water[23:8];
    assign w_lo[0]  = {i_soil_water[7:0], 8'h00};
    assign w_q[0]   = '0;
    assign w_ovf[0] = (i_soil_water[23:8] >= i_depth_mm);

    for (genvar k = 1; k < swp_pkg::DIV_STG; k++) begin : g_link
        assign w_rem[k] = r_rem[k-1];
        assign w_lo[k]  = r_lo[k-1];
        assign w_q[k]   = r_q[k-1];
        assign w_ovf[k] = r_ovf[k-1];
    end

    for (genvar k = 0; k < swp_pkg::DIV_STG; k++) begin : g_stg
        logic [15:0] n_rem;
        logic [15:0] n_lo;
        logic [15:0] n_q;
        logic [16:0] s_tmp;

        // STEP compare/subtract steps
        always_comb begin
            n_rem = w_rem[k];
            n_lo  = w_lo[k];
            n_q   = w_q[k];
            s_tmp = '0;
            for (int j = 0; j < STEP; j++) begin
                s_tmp = {n_rem, n_lo[15]};
                n_lo  = {n_lo[14:0], 1'b0};
                if (s_tmp >= {1'b0, i_depth_mm}) begin
                    n_rem = 16'(s_tmp - {1'b0, i_depth_mm});
                    n_q   = {n_q[14:0], 1'b1};
                end else begin
                    n_rem = s_tmp[15:0];
                    n_q   = {n_q[14:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv[k]) begin
                r_q[k]   <= n_q;
                r_ovf[k] <= w_ovf[k];
            end
        end

        if (k < swp_pkg::DIV_STG - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_adv[k]) begin
                    r_rem[k] <= n_rem;
                    r_lo[k]  <= n_lo;
                end
            end
        end
    end

    assign o_vol_content = r_ovf[swp_pkg::DIV_STG-1] ? 16'hFFFF
                                                     : r_q[swp_pkg::DIV_STG-1];

endmodule

[sv/soil_water_potential_van_genuchten.sv]
// ============================================================================
// soil_water_potential_van_genuchten - matric potential from soil water
// Divides soil water by depth, clamps to saturation and evaluates the van
// Genuchten retention curve with log2/exp2 tables, giving psi in pascals.
// ============================================================================
//
//  channel   dir  handshake          payload
//  i_req     in   valid/ready        soil_water (Q16.8)
//  o_res     out  valid/ready        psi_pa, vol_content, water_at_*, flags
//  apb       in   psel/penable/...   7 registers at 4*index
//
//  One request per cycle sustained while results are taken; the 4-stage
//  divider is followed by a chain of log/multiply/exp stages.
//  Each stage holds its own valid bit and loads when it is empty or its
//  successor moves, so a stalled result keeps earlier stages filling.
//  Reset clears the valid bits and loads the default site registers.
//  No memories; nothing to clear after reset.
//
module soil_water_potential_van_genuchten (
    input  logic        i_clk,
    input  logic        i_rst_n,
    swp_in_if.sink      i_req,
    swp_out_if.source   o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NS = swp_pkg::NSTG;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0] r_depth_mm;
    logic [15:0] r_theta_sat;
    logic [15:0] r_theta_res;
    logic [15:0] r_theta_fc;
    logic [23:0] r_inv_alpha_cm;
    logic [23:0] r_exp_m;
    logic [15:0] r_exp_inv_beta;
    logic [30:0] r_ia98;
    logic [23:0] r_wsat;
    logic [23:0] r_wfc;
    logic        w_wr;
    swp_pkg::t_reg_idx w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = swp_pkg::t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_mm     <= 16'd1000;
            r_theta_sat    <= 16'd25166;
            r_theta_res    <= 16'd1835;
            r_theta_fc     <= 16'd24248;
            r_inv_alpha_cm <= 24'd8533;
            r_exp_m        <= 24'hFC248A;
            r_exp_inv_beta <= 16'd48545;
        end else if (w_wr) begin
            case (w_idx)
                swp_pkg::REG_DEPTH_MM:     r_depth_mm     <= pwdata[15:0];
                swp_pkg::REG_THETA_SAT:    r_theta_sat    <= pwdata[15:0];
                swp_pkg::REG_THETA_RES:    r_theta_res    <= pwdata[15:0];
                swp_pkg::REG_THETA_FC:     r_theta_fc     <= pwdata[15:0];
                swp_pkg::REG_INV_ALPHA_CM: r_inv_alpha_cm <= pwdata[23:0];
                swp_pkg::REG_EXP_M:        r_exp_m        <= pwdata[23:0];
                swp_pkg::REG_EXP_INV_BETA: r_exp_inv_beta <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Readback
    always_comb begin
        case (w_idx)
            swp_pkg::REG_DEPTH_MM:     prdata = {16'h0000, r_depth_mm};
            swp_pkg::REG_THETA_SAT:    prdata = {16'h0000, r_theta_sat};
            swp_pkg::REG_THETA_RES:    prdata = {16'h0000, r_theta_res};
            swp_pkg::REG_THETA_FC:     prdata = {16'h0000, r_theta_fc};
            swp_pkg::REG_INV_ALPHA_CM: prdata = {8'h00, r_inv_alpha_cm};
            swp_pkg::REG_EXP_M:        prdata = {8'h00, r_exp_m};
            swp_pkg::REG_EXP_INV_BETA: prdata = {16'h0000, r_exp_inv_beta};
            default:                   prdata = '0;
        endcase
    end

    // Derived constants: 98 Pa/cm head scale, stored water amounts
    always_ff @(posedge i_clk) begin
        r_ia98 <= 31'(r_inv_alpha_cm) * 31'd98;
        r_wsat <= 24'((32'(r_theta_sat) * 32'(r_depth_mm)) >> 8);
        r_wfc  <= 24'((32'(r_theta_fc) * 32'(r_depth_mm)) >> 8);
    end

    // ------------------------------------------------------------------
    // Pipeline flow control
    // ------------------------------------------------------------------
    logic [NS-1:0] r_vld;
    logic [NS-1:0] w_adv;

    always_comb begin
        w_adv[NS-1] = !r_vld[NS-1] || o_res.ready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    assign i_req.ready = w_adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_req.valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 0..3: division
    // ------------------------------------------------------------------
    logic [15:0] w_vwc;

    swp_div u_div (
        .i_clk         (i_clk),
        .i_adv         (w_adv[swp_pkg::DIV_STG-1:0]),
        .i_soil_water  (i_req.soil_water),
        .i_depth_mm    (r_depth_mm),
        .o_vol_content (w_vwc)
    );

    // ------------------------------------------------------------------
    // Stage registers
    // ------------------------------------------------------------------
    swp_pkg::t_side     r_side [4:NS-1];
    logic        [15:0] r4_d1;
    logic        [15:0] r4_d2;
    logic        [21:0] r5_l1;
    logic        [21:0] r5_l2;
    logic signed [46:0] r6_pm;
    logic        [17:0] r7_e;
    logic        [5:0]  r7_ish;
    logic               r7_live;
    logic               r7_big;
    logic signed [30:0] r7_a;
    logic        [56:0] r8_q;
    logic        [5:0]  r8_eq;
    logic               r8_live;
    logic               r8_big;
    logic signed [30:0] r8_a;
    logic signed [31:0] r9_lq;
    logic               r9_live;
    logic signed [48:0] r10_py;
    logic               r10_live;
    logic        [17:0] r11_e2;
    logic signed [17:0] r11_s;
    logic               r11_live;
    logic        [48:0] r12_prod;
    logic signed [17:0] r12_s;
    logic               r12_live;
    logic        [40:0] r13_psi;

    // Stage 4: clamp to saturation, dry test, curve differences
    swp_pkg::t_side n4_side;
    logic [15:0]    n4_v;
    logic [15:0]    n4_d1;
    logic [15:0]    n4_d2;

    always_comb begin
        n4_side.vol_content = w_vwc;
        n4_side.wet         = w_vwc > r_theta_sat;
        n4_v                = n4_side.wet ? r_theta_sat : w_vwc;
        n4_side.dry         = n4_v <= r_theta_res;
        n4_d1               = n4_v - r_theta_res;
        n4_d2               = r_theta_sat - r_theta_res;
    end

    // Stage 5: log2 of both differences
    logic [5:0]  n5_e1;
    logic [5:0]  n5_e2;
    logic [31:0] n5_t1;
    logic [31:0] n5_t2;
    logic [21:0] n5_l1;
    logic [21:0] n5_l2;

    always_comb begin
        n5_e1 = swp_pkg::msb57(57'(r4_d1));
        n5_e2 = swp_pkg::msb57(57'(r4_d2));
        n5_t1 = 32'({r4_d1, 31'b0} >> n5_e1);
        n5_t2 = 32'({r4_d2, 31'b0} >> n5_e2);
        n5_l1 = swp_pkg::log2_q16(n5_e1, n5_t1);
        n5_l2 = swp_pkg::log2_q16(n5_e2, n5_t2);
    end

    // Stage 6: m * log2(r)
    logic signed [22:0] n6_lr;
    logic signed [46:0] n6_pm;

    always_comb begin
        n6_lr = $signed({1'b0, r5_l1}) - $signed({1'b0, r5_l2});
        n6_pm = $signed(r_exp_m) * n6_lr;
    end

    // Stage 7: r^m = 2^a, fraction through the exp table
    logic signed [30:0] n7_a;
    logic               n7_live;
    logic               n7_big;
    logic        [17:0] n7_e;

    always_comb begin
        n7_a    = r6_pm[46:16];
        n7_live = !n7_a[30] && (n7_a != '0);
        n7_big  = n7_a >= 31'sd2621440;
        n7_e    = swp_pkg::exp2_q16(n7_a[15:0]);
    end

    // Stage 8: r^m - 1 and its leading one
    logic [56:0] n8_p;
    logic [56:0] n8_q;
    logic [5:0]  n8_eq;

    always_comb begin
        n8_p  = 57'(r7_e) << r7_ish;
        n8_q  = n8_p - 57'd65536;
        n8_eq = swp_pkg::msb57(n8_q);
    end

    // Stage 9: log2(r^m - 1)
    logic [31:0]        n9_t;
    logic [21:0]        n9_lg;
    logic signed [31:0] n9_lq;
    logic               n9_live;

    always_comb begin
        n9_t    = 32'({r8_q, 31'b0} >> r8_eq);
        n9_lg   = swp_pkg::log2_q16(r8_eq, n9_t);
        n9_lq   = r8_big ? 32'(r8_a) : ($signed({10'b0, n9_lg}) - 32'sd1048576);
        n9_live = r8_live && (r8_big || (r8_q != '0));
    end

    // Stage 10: times 1/beta
    logic signed [48:0] n10_py;

    assign n10_py = r9_lq * $signed({1'b0, r_exp_inv_beta});

    // Stage 11: exp2 of the fraction, integer part sets the shift
    logic signed [32:0] n11_y;
    logic signed [16:0] n11_yi;
    logic        [17:0] n11_e2;
    logic signed [17:0] n11_s;

    always_comb begin
        n11_y  = r10_py[48:16];
        n11_yi = n11_y[32:16];
        n11_e2 = swp_pkg::exp2_q16(n11_y[15:0]);
        n11_s  = $signed({n11_yi[16], n11_yi}) - 18'sd24;
    end

    // Stage 12: scale by 98/alpha
    logic [48:0] n12_prod;

    assign n12_prod = 49'(r_ia98) * 49'(r11_e2);

    // Stage 13: shift, round half up, saturate, negate
    logic [88:0] n13_wide;
    logic [17:0] n13_k;
    logic [49:0] n13_sum;
    logic [49:0] n13_shr;
    logic [40:0] n13_mag;

    always_comb begin
        n13_wide = 89'(r12_prod) << r12_s[5:0];
        n13_k    = 18'(-r12_s);
        n13_sum  = 50'(r12_prod) + (50'd1 << (n13_k[5:0] - 6'd1));
        n13_shr  = n13_sum >> n13_k[5:0];
        if (r_side[12].dry) begin
            n13_mag = swp_pkg::PSI_LIMIT;
        end else if (!r12_live || (r12_prod == '0)) begin
            n13_mag = '0;
        end else if (!r12_s[17]) begin
            if (r12_s > 18'sd40 || n13_wide > 89'(swp_pkg::PSI_LIMIT)) begin
                n13_mag = swp_pkg::PSI_LIMIT;
            end else begin
                n13_mag = n13_wide[40:0];
            end
        end else if (n13_k > 18'd48) begin
            n13_mag = '0;
        end else if (n13_shr > 50'(swp_pkg::PSI_LIMIT)) begin
            n13_mag = swp_pkg::PSI_LIMIT;
        end else begin
            n13_mag = n13_shr[40:0];
        end
    end

    // Stage register loads
    always_ff @(posedge i_clk) begin
        if (w_adv[4]) begin
            r_side[4] <= n4_side;
            r4_d1     <= n4_d1;
            r4_d2     <= n4_d2;
        end
        for (int k = 5; k < NS; k++) begin
            if (w_adv[k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
        if (w_adv[5]) begin
            r5_l1 <= n5_l1;
            r5_l2 <= n5_l2;
        end
        if (w_adv[6]) begin
            r6_pm <= n6_pm;
        end
        if (w_adv[7]) begin
            r7_e    <= n7_e;
            r7_ish  <= n7_a[21:16];
            r7_live <= n7_live;
            r7_big  <= n7_big;
            r7_a    <= n7_a;
        end
        if (w_adv[8]) begin
            r8_q    <= n8_q;
            r8_eq   <= n8_eq;
            r8_live <= r7_live;
            r8_big  <= r7_big;
            r8_a    <= r7_a;
        end
        if (w_adv[9]) begin
            r9_lq   <= n9_lq;
            r9_live <= n9_live;
        end
        if (w_adv[10]) begin
            r10_py   <= n10_py;
            r10_live <= r9_live;
        end
        if (w_adv[11]) begin
            r11_e2   <= n11_e2;
            r11_s    <= n11_s;
            r11_live <= r10_live;
        end
        if (w_adv[12]) begin
            r12_prod <= n12_prod;
            r12_s    <= r11_s;
            r12_live <= r11_live;
        end
        if (w_adv[13]) begin
            r13_psi <= 41'd0 - n13_mag;
        end
    end

    // ------------------------------------------------------------------
    // Result channel
    // ------------------------------------------------------------------
    assign o_res.valid                   = r_vld[NS-1];
    assign o_res.psi_pa                  = $signed(r13_psi);
    assign o_res.vol_content             = r_side[NS-1].vol_content;
    assign o_res.dry_flag                = r_side[NS-1].dry;
    assign o_res.wet_clamped             = r_side[NS-1].wet;
    assign o_res.water_at_saturation     = r_wsat;
    assign o_res.water_at_field_capacity = r_wfc;

endmodule

[sv/swp_chk.sv]
// ============================================================================
// swp_chk - port-level checks for the soil water potential block
// Watches the result channel for reset, sign, dry saturation and stall behavior.
// ============================================================================
module swp_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [40:0] i_psi_pa,
    input logic               i_dry_flag
);

    // Nothing is presented in the cycle after reset
    a_rst_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

    // A stalled result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_psi_pa))
        else $error("stalled result changed");

    // Dry soil reports the saturated potential
    a_dry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_dry_flag |-> i_psi_pa == -41'sh100_0000_0000)
        else $error("dry result without saturated psi");

    // Potential is never positive
    a_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_psi_pa[40] || (i_psi_pa == '0))
        else $error("positive psi");

endmodule

bind soil_water_potential_van_genuchten swp_chk u_swp_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_psi_pa    (o_res.psi_pa),
    .i_dry_flag  (o_res.dry_flag)
);
